// ===== sv/scca_pkg.sv =====
// Shared constants, types and codes for the scan-context column alignment block.
package scca_pkg;

  localparam int MAX_RINGS   = 32;
  localparam int MAX_SECTORS = 64;
  localparam int CELL_COUNT  = MAX_RINGS * MAX_SECTORS;

  localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int RIDX_W = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
  localparam int SIDX_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;

  localparam int CMD_W      = 2;
  localparam int INDEX_W    = 11;
  localparam int HEIGHT_W   = 16;
  localparam int NR_W       = 6;
  localparam int NS_W       = 7;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int SHIFT_W    = 6;
  localparam int DIST_OUT_W = 27;

  // Sum of absolute differences over every cell of one shift.
  localparam int DIST_W = ADDR_W + HEIGHT_W;
  localparam int SUM_W  = (DIST_W > DIST_OUT_W) ? DIST_W : DIST_OUT_W;

  localparam logic [DIST_OUT_W-1:0] DIST_MAX = '1;

  localparam logic [NR_W-1:0] RINGS_RESET   = NR_W'(20);
  localparam logic [NS_W-1:0] SECTORS_RESET = NS_W'(60);

  localparam logic [CMD_W-1:0] CMD_LOAD_SRC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_TGT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALIGN    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_RINGS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SECTORS = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_REPORT
  } scca_state_t;

  typedef struct packed {
    logic init;
    logic step;
    logic wr_src;
    logic wr_tgt;
  } scca_ctrl_t;

  typedef struct packed {
    logic issue_last;
    logic fin;
  } scca_stat_t;

endpackage

// ===== sv/scca_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module scca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/scca_ctrl.sv =====
// Controller state machine: accepts commands and sequences the shift search.
module scca_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [scca_pkg::CMD_W-1:0]    cmd,
  input  scca_pkg::scca_stat_t          stat,
  output scca_pkg::scca_ctrl_t          ctrl,
  output logic                          busy,
  output logic                          done
);

  scca_pkg::scca_state_t state, state_next;
  logic accept;

  assign accept = start && (state == scca_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scca_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      scca_pkg::ST_IDLE: begin
        busy        = 1'b0;
        ctrl.wr_src = accept && (cmd == scca_pkg::CMD_LOAD_SRC);
        ctrl.wr_tgt = accept && (cmd == scca_pkg::CMD_LOAD_TGT);
        if (accept && (cmd == scca_pkg::CMD_ALIGN)) begin
          ctrl.init  = 1'b1;
          state_next = scca_pkg::ST_RUN;
        end
      end
      scca_pkg::ST_RUN: begin
        ctrl.step = 1'b1;
        if (stat.issue_last) begin
          state_next = scca_pkg::ST_DRAIN;
        end
      end
      scca_pkg::ST_DRAIN: begin
        if (stat.fin) begin
          state_next = scca_pkg::ST_REPORT;
        end
      end
      scca_pkg::ST_REPORT: begin
        done       = 1'b1;
        state_next = scca_pkg::ST_IDLE;
      end
      default: begin
        state_next = scca_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/scca_dp.sv =====
// Datapath: configuration registers, cell stores, address counters and SAD pipeline.
module scca_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [scca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scca_pkg::CFG_W-1:0]        cfg_data,
  input  logic [scca_pkg::INDEX_W-1:0]      cell_index,
  input  logic signed [scca_pkg::HEIGHT_W-1:0] height,
  input  scca_pkg::scca_ctrl_t              ctrl,
  output scca_pkg::scca_stat_t              stat,
  output logic [scca_pkg::SHIFT_W-1:0]      match_shift,
  output logic [scca_pkg::DIST_OUT_W-1:0]   best_distance
);

  logic [scca_pkg::NR_W-1:0] num_rings;
  logic [scca_pkg::NS_W-1:0] num_sectors;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rings   <= scca_pkg::RINGS_RESET;
      num_sectors <= scca_pkg::SECTORS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == scca_pkg::CFG_NUM_RINGS) begin
        num_rings <= cfg_data[scca_pkg::NR_W-1:0];
      end
      if (cfg_index == scca_pkg::CFG_NUM_SECTORS) begin
        num_sectors <= cfg_data[scca_pkg::NS_W-1:0];
      end
    end
  end

  // Register value zero counts as one; values above the maximum saturate.
  logic [scca_pkg::RIDX_W-1:0] rings_m1_eff;
  logic [scca_pkg::SIDX_W-1:0] sectors_m1_eff;

  always_comb begin
    if (num_rings == '0) begin
      rings_m1_eff = '0;
    end else if (32'(num_rings) > scca_pkg::MAX_RINGS) begin
      rings_m1_eff = scca_pkg::RIDX_W'(scca_pkg::MAX_RINGS - 1);
    end else begin
      rings_m1_eff = scca_pkg::RIDX_W'(num_rings - 1'b1);
    end
    if (num_sectors == '0) begin
      sectors_m1_eff = '0;
    end else if (32'(num_sectors) > scca_pkg::MAX_SECTORS) begin
      sectors_m1_eff = scca_pkg::SIDX_W'(scca_pkg::MAX_SECTORS - 1);
    end else begin
      sectors_m1_eff = scca_pkg::SIDX_W'(num_sectors - 1'b1);
    end
  end

  // Search counters, latched at the start of a search.
  logic [scca_pkg::RIDX_W-1:0] r_m1;
  logic [scca_pkg::SIDX_W-1:0] s_m1;
  logic [scca_pkg::ADDR_W-1:0] s_cnt;
  logic [scca_pkg::SIDX_W-1:0] k, c, tc;
  logic [scca_pkg::RIDX_W-1:0] rr;
  logic [scca_pkg::ADDR_W-1:0] base;
  logic last_c, last_r, last_k;

  assign last_c = (c == s_m1);
  assign last_r = (rr == r_m1);
  assign last_k = (k == s_m1);

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      r_m1  <= rings_m1_eff;
      s_m1  <= sectors_m1_eff;
      s_cnt <= scca_pkg::ADDR_W'(sectors_m1_eff) + 1'b1;
      k     <= '0;
      c     <= '0;
      tc    <= '0;
      rr    <= '0;
      base  <= '0;
    end else if (ctrl.step) begin
      if (!last_c) begin
        c  <= c + 1'b1;
        tc <= (tc == s_m1) ? '0 : tc + 1'b1;
      end else begin
        c <= '0;
        if (!last_r) begin
          rr   <= rr + 1'b1;
          base <= base + s_cnt;
          tc   <= k;
        end else begin
          rr   <= '0;
          base <= '0;
          k    <= k + 1'b1;
          tc   <= k + 1'b1;
        end
      end
    end
  end

  // Cell stores.
  logic [scca_pkg::ADDR_W-1:0]   waddr, raddr_s, raddr_t;
  logic                          in_range;
  logic [scca_pkg::HEIGHT_W-1:0] src_q, tgt_q;

  assign waddr    = scca_pkg::ADDR_W'(cell_index);
  assign in_range = 32'(cell_index) < scca_pkg::CELL_COUNT;
  assign raddr_s  = base + scca_pkg::ADDR_W'(c);
  assign raddr_t  = base + scca_pkg::ADDR_W'(tc);

  scca_ram #(
    .WIDTH (scca_pkg::HEIGHT_W),
    .DEPTH (scca_pkg::CELL_COUNT)
  ) u_src_ram (
    .clk   (clk),
    .we    (ctrl.wr_src && in_range),
    .waddr (waddr),
    .wdata (height),
    .raddr (raddr_s),
    .rdata (src_q)
  );

  scca_ram #(
    .WIDTH (scca_pkg::HEIGHT_W),
    .DEPTH (scca_pkg::CELL_COUNT)
  ) u_tgt_ram (
    .clk   (clk),
    .we    (ctrl.wr_tgt && in_range),
    .waddr (waddr),
    .wdata (height),
    .raddr (raddr_t),
    .rdata (tgt_q)
  );

  // Stage A: read data arrives together with these tags.
  logic                        va, end_a, first_a, last_a;
  logic [scca_pkg::SIDX_W-1:0] k_a;
  // Stage B: absolute difference.
  logic                        vb, end_b, first_b, last_b;
  logic [scca_pkg::SIDX_W-1:0] k_b;
  logic [scca_pkg::HEIGHT_W-1:0] absd;
  logic signed [scca_pkg::HEIGHT_W:0] diff;

  assign diff = {src_q[scca_pkg::HEIGHT_W-1], src_q}
              - {tgt_q[scca_pkg::HEIGHT_W-1], tgt_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      va <= ctrl.step;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    end_a   <= last_c && last_r;
    first_a <= (k == '0);
    last_a  <= last_c && last_r && last_k;
    k_a     <= k;
    end_b   <= end_a;
    first_b <= first_a;
    last_b  <= last_a;
    k_b     <= k_a;
    absd    <= diff[scca_pkg::HEIGHT_W]
             ? scca_pkg::HEIGHT_W'(-diff) : scca_pkg::HEIGHT_W'(diff);
  end

  // Stage C: accumulate and keep the first minimum.
  logic [scca_pkg::SUM_W-1:0]  acc, sum, best;
  logic [scca_pkg::SIDX_W-1:0] best_k;

  assign sum  = acc + scca_pkg::SUM_W'(absd);
  assign stat = '{issue_last: ctrl.step && last_c && last_r && last_k,
                  fin:        vb && last_b};

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      acc <= '0;
    end else if (vb) begin
      if (end_b) begin
        acc <= '0;
        if (first_b || (sum < best)) begin
          best   <= sum;
          best_k <= k_b;
        end
      end else begin
        acc <= sum;
      end
    end
  end

  assign match_shift   = scca_pkg::SHIFT_W'(best_k);
  assign best_distance = (best > scca_pkg::SUM_W'(scca_pkg::DIST_MAX))
                       ? scca_pkg::DIST_MAX : scca_pkg::DIST_OUT_W'(best);

endmodule

// ===== sv/scan_context_column_align_core.sv =====
// Top level of the scan-context column alignment block.
// A load command (cmd 0 source, cmd 1 target) leaves the block idle, so cells can be
// written back to back while busy is low. An align command (cmd 2) raises busy
// and walks all rings times sectors times sectors cell pairs, one pair per cycle
// from the two cell RAMs' single read ports. The result appears on match_shift
// and best_distance for exactly one cycle with done high and must be captured
// then: the receiver cannot stall it. Busy drops the cycle after done.
// Only cells that have been loaded may be covered by a search.
module scan_context_column_align_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [scca_pkg::CMD_W-1:0]           cmd,
  input  logic [scca_pkg::INDEX_W-1:0]         cell_index,
  input  logic signed [scca_pkg::HEIGHT_W-1:0] height,
  output logic                                 done,
  output logic [scca_pkg::SHIFT_W-1:0]         match_shift,
  output logic [scca_pkg::DIST_OUT_W-1:0]      best_distance,
  input  logic                                 cfg_we,
  input  logic [scca_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [scca_pkg::CFG_W-1:0]           cfg_data
);

  scca_pkg::scca_ctrl_t ctrl;
  scca_pkg::scca_stat_t stat;

  scca_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (done)
  );

  scca_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cell_index    (cell_index),
    .height        (height),
    .ctrl          (ctrl),
    .stat          (stat),
    .match_shift   (match_shift),
    .best_distance (best_distance)
  );

endmodule
